@@ design/lftc_pkg.sv @@
// Package for the LFU tag cache lookup block: sizes, status codes, payload
// structs and the command/status structs between controller and datapath.
// No dependencies.
package lftc_pkg;

   // Store geometry and field widths.
   localparam int ENTRIES      = 16;
   localparam int COUNT_BITS   = 16;
   localparam int KEY_BITS     = 32;
   localparam int DATA_BITS    = 32;
   localparam int SESSION_BITS = 16;
   localparam int SLOT_BITS    = 4;
   localparam int IDX_BITS     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [IDX_BITS-1:0]   IDX_LAST  = IDX_BITS'(ENTRIES - 1);

   // Result status codes.
   localparam logic [1:0] STATUS_HIT  = 2'd0;
   localparam logic [1:0] STATUS_FILL = 2'd1;
   localparam logic [1:0] STATUS_FAIL = 2'd2;

   // One lookup request.
   typedef struct packed {
      logic [SESSION_BITS-1:0] session_num;
      logic [KEY_BITS-1:0]     db_key;
      logic [KEY_BITS-1:0]     rel_key;
      logic [DATA_BITS-1:0]    fill_data;
      logic                    fetch_ok;
   } req_type;

   // One lookup result.
   typedef struct packed {
      logic [1:0]           status;
      logic [DATA_BITS-1:0] data_out;
      logic [SLOT_BITS-1:0] slot_used;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic step;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit_now;
      logic scan_last;
      logic out_free;
   } status_type;

   // Low slot bits of an entry number, zero extended when the index is narrow.
   function automatic logic [SLOT_BITS-1:0] slot_of(input logic [IDX_BITS-1:0] idx);
      logic [IDX_BITS+SLOT_BITS-1:0] wide;
      wide = {{SLOT_BITS{1'b0}}, idx};
      return wide[SLOT_BITS-1:0];
   endfunction

endpackage

@@ design/lftc_ctrl.sv @@
// Controller of the LFU tag cache lookup block: sequences accept, scan and
// commit of one lookup. Depends on lftc_pkg.
module lftc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lftc_pkg::status_type stat,
   output lftc_pkg::cmd_type    cmd
);
   import lftc_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (stat.hit_now || stat.scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A transfer in always starts a scan.
   a_start_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_SCAN))
      else $error("accepted request did not start a scan");

   // A scan ends on a hit or at the last entry, and then commits.
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && (stat.hit_now || stat.scan_last)) |=> (state_ff == ST_COMMIT))
      else $error("scan did not end on hit or last entry");

   // A commit with a free result register returns the controller to idle.
   a_commit_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && stat.out_free) |=> (state_ff == ST_IDLE))
      else $error("commit did not return to idle");

endmodule

@@ design/lftc_dpath.sv @@
// Datapath of the LFU tag cache lookup block: entry store, scan index,
// hit and victim tracking, and the result register. Depends on lftc_pkg.
module lftc_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_wdata,
   input  lftc_pkg::req_type    req_data,
   input  lftc_pkg::cmd_type    cmd,
   output lftc_pkg::status_type stat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lftc_pkg::rsp_type    rsp_data
);
   import lftc_pkg::*;

   // Entry store; a zero count marks an empty entry.
   logic [KEY_BITS-1:0]     db_ff    [ENTRIES];
   logic [KEY_BITS-1:0]     rel_ff   [ENTRIES];
   logic [COUNT_BITS-1:0]   cnt_ff   [ENTRIES];
   logic [SESSION_BITS-1:0] sess_ff  [ENTRIES];
   logic [DATA_BITS-1:0]    value_ff [ENTRIES];

   logic                    session_local_ff, session_local_in;
   req_type                 req_ff, req_in;
   logic [IDX_BITS-1:0]     idx_ff, idx_in;
   logic [IDX_BITS-1:0]     victim_ff, victim_in;
   logic [IDX_BITS-1:0]     hit_slot_ff, hit_slot_in;
   logic [COUNT_BITS-1:0]   best_ff, best_in;
   logic [COUNT_BITS-1:0]   hit_cnt_ff, hit_cnt_in;
   logic [DATA_BITS-1:0]    hit_data_ff, hit_data_in;
   logic                    hit_ff, hit_in;
   logic                    locked_ff, locked_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [COUNT_BITS-1:0]   e_cnt;
   logic                    e_foreign;
   logic                    e_hit;
   logic                    e_take;
   logic [COUNT_BITS-1:0]   hit_cnt_sat;

   // Current entry of the scan.
   always_comb begin
      e_cnt     = cnt_ff[idx_ff];
      e_foreign = session_local_ff && (sess_ff[idx_ff] != req_ff.session_num);
      e_hit     = (e_cnt != '0) && !e_foreign &&
                  (db_ff[idx_ff] == req_ff.db_key) && (rel_ff[idx_ff] == req_ff.rel_key);
      e_take    = e_foreign || (e_cnt == '0);
   end

   assign hit_cnt_sat = (hit_cnt_ff == COUNT_MAX) ? hit_cnt_ff : hit_cnt_ff + COUNT_ONE;

   // Status toward the controller.
   always_comb begin
      stat.hit_now   = e_hit;
      stat.scan_last = (idx_ff == IDX_LAST);
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // Scan and victim tracking.
   always_comb begin
      session_local_in = csr_we ? csr_wdata : session_local_ff;
      req_in      = req_ff;
      idx_in      = idx_ff;
      victim_in   = victim_ff;
      hit_slot_in = hit_slot_ff;
      best_in     = best_ff;
      hit_cnt_in  = hit_cnt_ff;
      hit_data_in = hit_data_ff;
      hit_in      = hit_ff;
      locked_in   = locked_ff;
      if (cmd.start) begin
         req_in    = req_data;
         idx_in    = '0;
         victim_in = '0;
         best_in   = COUNT_MAX;
         hit_in    = 1'b0;
         locked_in = 1'b0;
      end else if (cmd.step) begin
         if (e_hit) begin
            hit_in      = 1'b1;
            hit_slot_in = idx_ff;
            hit_cnt_in  = e_cnt;
            hit_data_in = value_ff[idx_ff];
         end else begin
            if (!locked_ff) begin
               if (e_take) begin
                  victim_in = idx_ff;
                  locked_in = 1'b1;
               end else if (e_cnt < best_ff) begin
                  victim_in = idx_ff;
                  best_in   = e_cnt;
               end
            end
            if (idx_ff != IDX_LAST) begin
               idx_in = idx_ff + IDX_BITS'(1);
            end
         end
      end
   end

   // Result register: loaded on commit, cleared when the transfer completes.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         priority if (hit_ff) begin
            rsp_in.status    = STATUS_HIT;
            rsp_in.data_out  = hit_data_ff;
            rsp_in.slot_used = slot_of(hit_slot_ff);
         end else if (req_ff.fetch_ok) begin
            rsp_in.status    = STATUS_FILL;
            rsp_in.data_out  = req_ff.fill_data;
            rsp_in.slot_used = slot_of(victim_ff);
         end else begin
            rsp_in.status    = STATUS_FAIL;
            rsp_in.data_out  = '0;
            rsp_in.slot_used = '0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         session_local_ff <= 1'b0;
         hit_ff           <= 1'b0;
         locked_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         session_local_ff <= session_local_in;
         hit_ff           <= hit_in;
         locked_ff        <= locked_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      victim_ff   <= victim_in;
      hit_slot_ff <= hit_slot_in;
      best_ff     <= best_in;
      hit_cnt_ff  <= hit_cnt_in;
      hit_data_ff <= hit_data_in;
      rsp_ff      <= rsp_in;
   end

   // Use counts: cleared at reset, bumped on a hit, set to one on a fill.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         if (hit_ff) begin
            cnt_ff[hit_slot_ff] <= hit_cnt_sat;
         end else if (req_ff.fetch_ok) begin
            cnt_ff[victim_ff] <= COUNT_ONE;
         end
      end
   end

   // Entry contents are written only on a fill.
   always_ff @(posedge clock) begin
      if (cmd.commit && !hit_ff && req_ff.fetch_ok) begin
         db_ff[victim_ff]    <= req_ff.db_key;
         rel_ff[victim_ff]   <= req_ff.rel_key;
         sess_ff[victim_ff]  <= req_ff.session_num;
         value_ff[victim_ff] <= req_ff.fill_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A commit never overwrites a result that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("commit while result register is occupied");

   // Every commit presents a result in the next cycle.
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not raise result valid");

   // Once a victim is taken outright, later entries do not displace it.
   a_victim_locked: assert property (@(posedge clock) disable iff (reset)
      (locked_ff && !cmd.start) |=> $stable(victim_ff))
      else $error("locked victim changed during scan");

endmodule

@@ design/lfu_tag_cache_lookup.sv @@
// Top level of the LFU tag cache lookup block: joins the controller and the
// datapath. Depends on lftc_pkg, lftc_ctrl and lftc_dpath.
//
// Fully associative 16-entry lookup cache with least-frequently-used
// replacement. One lookup is handled at a time: the transfer cycle, then a
// sequential scan through the entry store, one entry per cycle (it
// stops at the first hit, and covers all 16 entries on a miss), then a
// commit cycle that updates the store and loads the result register. A
// finished result waits in its own register, so the next request is
// taken while it is still pending; the commit stalls only if the
// previous result has not yet been transferred. The session_local
// register is written through csr_we/csr_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce it.
// Reset empties the store at once.
module lfu_tag_cache_lookup (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  lftc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lftc_pkg::rsp_type rsp_data
);
   import lftc_pkg::*;

   cmd_type    cmd;
   status_type stat;

   // Sequencer.
   lftc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Store, scan and result register.
   lftc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sim/lfu_tag_cache_lookup_test.sv @@
// Self-checking testbench for lfu_tag_cache_lookup: a tag store predictor
// checks every result transfer. Depends on lftc_pkg and the block's RTL.
`timescale 1ns / 1ps

module lfu_tag_cache_lookup_test;
   import lftc_pkg::*;

   localparam int KEY_POOL      = 32;
   localparam int LONG_HOLD     = 300;
   localparam int REPEAT_HITS   = 60;
   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_LIMIT  = 10;

   typedef enum int {READY_ALWAYS, READY_HALF, READY_MOST, READY_SPARSE} ready_style_type;

   // Predicts each lookup result from its own copy of the entry store.
   class lookup_scoreboard;
      logic [KEY_BITS-1:0]     tag_db    [ENTRIES];
      logic [KEY_BITS-1:0]     tag_rel   [ENTRIES];
      logic [COUNT_BITS-1:0]   use_count [ENTRIES];
      logic [SESSION_BITS-1:0] owner     [ENTRIES];
      logic [DATA_BITS-1:0]    stored    [ENTRIES];
      logic                    session_local;
      rsp_type                 pending_results[$];
      int                      mismatches;

      function new();
         int i;
         for (i = 0; i < ENTRIES; i = i + 1) begin
            tag_db[i]    = '0;
            tag_rel[i]   = '0;
            use_count[i] = '0;
            owner[i]     = '0;
            stored[i]    = '0;
         end
         session_local = 1'b0;
         mismatches    = 0;
      endfunction

      function void set_session_local(input logic mode);
         session_local = mode;
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      // Work out the result of an accepted lookup and update the store.
      function void note_lookup(input req_type item);
         rsp_type               want;
         logic [COUNT_BITS-1:0] best;
         int                    i;
         int                    victim;
         bit                    found;
         bit                    taken;
         want  = '0;
         found = 1'b0;
         // Hit search: empty entries never hit, other sessions are skipped
         // in session-local mode.
         for (i = 0; i < ENTRIES && !found; i = i + 1) begin
            if (use_count[i] != '0 && (!session_local || owner[i] == item.session_num) &&
                tag_db[i] == item.db_key && tag_rel[i] == item.rel_key) begin
               found = 1'b1;
               if (use_count[i] != COUNT_MAX) begin
                  use_count[i] = use_count[i] + 1'b1;
               end
               want.status    = STATUS_HIT;
               want.data_out  = stored[i];
               want.slot_used = i[SLOT_BITS-1:0];
            end
         end
         if (!found && !item.fetch_ok) begin
            want.status = STATUS_FAIL;
         end else if (!found) begin
            // Victim: foreign session or empty entry at once, else the first
            // strictly smallest unsaturated count, else entry 0.
            victim = 0;
            best   = COUNT_MAX;
            taken  = 1'b0;
            for (i = 0; i < ENTRIES && !taken; i = i + 1) begin
               if ((session_local && owner[i] != item.session_num) || use_count[i] == '0) begin
                  victim = i;
                  taken  = 1'b1;
               end else if (use_count[i] < best) begin
                  best   = use_count[i];
                  victim = i;
               end
            end
            tag_db[victim]    = item.db_key;
            tag_rel[victim]   = item.rel_key;
            use_count[victim] = COUNT_ONE;
            owner[victim]     = item.session_num;
            stored[victim]    = item.fill_data;
            want.status       = STATUS_FILL;
            want.data_out     = item.fill_data;
            want.slot_used    = victim[SLOT_BITS-1:0];
         end
         pending_results.push_back(want);
      endfunction

      // Compare one result transfer with the oldest prediction.
      function void check_result(input rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: result with none pending: status %0d data %h slot %0d",
                        $realtime, got.status, got.data_out, got.slot_used);
            end
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status || got.data_out !== want.data_out ||
             got.slot_used !== want.slot_used) begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: mismatch: expected status %0d data %h slot %0d,",
                        $realtime, want.status, want.data_out, want.slot_used);
               $display("   got status %0d data %h slot %0d",
                        got.status, got.data_out, got.slot_used);
            end
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    csr_we    = 1'b0;
   logic    csr_wdata = 1'b0;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   lookup_scoreboard        sb;
   int                      hold_requests = 0;
   logic [KEY_BITS-1:0]     pool_db  [KEY_POOL];
   logic [KEY_BITS-1:0]     pool_rel [KEY_POOL];
   logic [SESSION_BITS-1:0] sess_pool[3];

   lfu_tag_cache_lookup dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 8 ns clock.
   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog for a hung run.
   initial begin
      #80_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Monitor both channels; results are checked before the same edge's request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_data);
         end
         if (req_valid && req_ready) begin
            sb.note_lookup(req_data);
         end
      end
   end

   // Receiver: a pattern of ready styles, with a long hold on request.
   initial begin
      int              holds_done;
      int              hold_left;
      int              seg_left;
      ready_style_type style;
      holds_done = 0;
      hold_left  = 0;
      seg_left   = 0;
      style      = READY_ALWAYS;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done = holds_done + 1;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               style    = ready_style_type'($urandom_range(0, 3));
               seg_left = $urandom_range(10, 120);
            end
            seg_left = seg_left - 1;
            unique case (style)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_HALF:   rsp_ready <= ($urandom_range(0, 1) == 0);
               READY_MOST:   rsp_ready <= ($urandom_range(0, 6) != 0);
               default:      rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic req_type make_lookup(input logic [SESSION_BITS-1:0] sess,
                                           input logic [KEY_BITS-1:0] db,
                                           input logic [KEY_BITS-1:0] rel,
                                           input logic [DATA_BITS-1:0] fill,
                                           input logic ok);
      req_type item;
      item.session_num = sess;
      item.db_key      = db;
      item.rel_key     = rel;
      item.fill_data   = fill;
      item.fetch_ok    = ok;
      return item;
   endfunction

   // Mostly known keys so that hits and replacements are frequent; some near
   // misses on the relation key and some fully random keys.
   function automatic req_type random_lookup(input int pool_size);
      req_type item;
      int      pick;
      int      slot;
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, pool_size - 1);
      item.db_key  = pool_db[slot];
      item.rel_key = pool_rel[slot];
      if (pick < 8) begin
         item.rel_key = pool_rel[$urandom_range(0, pool_size - 1)];
      end else if (pick < 14) begin
         item.db_key  = $urandom;
         item.rel_key = $urandom;
      end
      if ($urandom_range(0, 4) != 0) begin
         item.session_num = sess_pool[$urandom_range(0, 2)];
      end else begin
         item.session_num = SESSION_BITS'($urandom);
      end
      item.fill_data = $urandom;
      item.fetch_ok  = ($urandom_range(0, 9) != 0);
      return item;
   endfunction

   // Offer one lookup and hold it until the transfer; valid stays high.
   task automatic send_lookup(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic sender_gap(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Pause the sender until every predicted result has been transferred.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_mode(input logic mode);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_session_local(mode);
   endtask

   // One random phase: bursts with gaps, a long receiver hold at the start.
   task automatic run_phase(input logic mode, input int pool_size, input int count);
      int burst_left;
      int n;
      write_mode(mode);
      hold_requests = hold_requests + 1;
      burst_left = 0;
      for (n = 0; n < count; n = n + 1) begin
         if (burst_left == 0) begin
            sender_gap($urandom_range(1, 30));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 30);
         end
         burst_left = burst_left - 1;
         send_lookup(random_lookup(pool_size));
      end
      wait_drained();
   endtask

   initial begin
      int i;
      sb = new();
      for (i = 0; i < KEY_POOL; i = i + 1) begin
         pool_db[i]  = $urandom;
         pool_rel[i] = $urandom;
         // Some keys share a database tag and differ only in the relation.
         if (i % 4 == 3) begin
            pool_db[i] = pool_db[i - 1];
         end
      end
      pool_db[0]   = '0;
      pool_rel[0]  = '0;
      pool_db[1]   = '1;
      pool_rel[1]  = '1;
      sess_pool[0] = '0;
      sess_pool[1] = 16'd1;
      sess_pool[2] = '1;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Shared mode: an empty store never hits, even on all-zero keys.
      write_mode(1'b0);
      send_lookup(make_lookup('0, '0, '0, 32'd5, 1'b0));
      send_lookup(make_lookup('0, '0, '0, '1, 1'b1));
      send_lookup(make_lookup('0, '0, '0, 32'd7, 1'b0));
      send_lookup(make_lookup('1, '1, '1, '0, 1'b1));
      // Session is ignored here; a single differing key is a miss.
      send_lookup(make_lookup('0, '1, '1, '1, 1'b0));
      send_lookup(make_lookup('0, '1, '0, '1, 1'b0));
      send_lookup(make_lookup('0, '0, '1, '1, 1'b0));
      // Fill every remaining entry, then evict the first least-used one.
      for (i = 2; i < ENTRIES; i = i + 1) begin
         send_lookup(make_lookup(16'(i), 32'(i), 32'(i), $urandom, 1'b1));
      end
      send_lookup(make_lookup('0, 32'hDEAD_0001, 32'hBEEF_0001, $urandom, 1'b1));
      wait_drained();

      // Session-local mode: own-session hit, foreign entry taken as victim,
      // then the old owner misses.
      write_mode(1'b1);
      send_lookup(make_lookup('0, '0, '0, 32'd9, 1'b0));
      send_lookup(make_lookup(16'd7, '0, '0, 32'h1234_5678, 1'b1));
      send_lookup(make_lookup('0, '0, '0, 32'd9, 1'b0));
      wait_drained();

      // Hit one entry many times in a row, with fetches that pass and fail.
      write_mode(1'b0);
      send_lookup(make_lookup(16'h0042, 32'h5A5A_5A5A, 32'hC3C3_C3C3, $urandom, 1'b1));
      for (i = 0; i < REPEAT_HITS; i = i + 1) begin
         send_lookup(make_lookup(16'h0042, 32'h5A5A_5A5A, 32'hC3C3_C3C3, $urandom,
                                 1'($urandom_range(0, 1))));
      end
      send_lookup(make_lookup('0, 32'h0BAD_F00D, 32'h0000_1111, $urandom, 1'b1));
      wait_drained();

      // Random phases over both modes and several key pool sizes.
      run_phase(1'b0, 20, 400);
      run_phase(1'b1, 10, 400);
      run_phase(1'b1, KEY_POOL, 400);
      run_phase(1'b0, KEY_POOL, 400);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
